// ----- rtl/core/sbq_pkg.sv -----
// Shared types, codes and filter coefficient tables of the biquad chain.
package sbq_pkg;

   localparam int NumBiquads = 4;
   localparam int NumTaps    = 5;

   // biquad indexes
   localparam logic [1:0] BQ_HP250 = 2'd0;
   localparam logic [1:0] BQ_LP5K  = 2'd1;
   localparam logic [1:0] BQ_LP550 = 2'd2;
   localparam logic [1:0] BQ_HP1K2 = 2'd3;

   // tap codes, in summation order
   localparam logic [2:0] TAP_B0 = 3'd0;
   localparam logic [2:0] TAP_B1 = 3'd1;
   localparam logic [2:0] TAP_A1 = 3'd2;
   localparam logic [2:0] TAP_B2 = 3'd3;
   localparam logic [2:0] TAP_A2 = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_HIGHPASS_ENABLE = 2'd0;
   localparam logic [1:0] CSR_LOWPASS_ENABLE  = 2'd1;
   localparam logic [1:0] CSR_NOTCH_ENABLE    = 2'd2;

   // divide by reciprocal: for 0 <= n <= 2^31, n / d == (n * m) >> s
   // with s = 31 + ceil(log2 d) and m = ceil(2^s / d), m below 2^32
   localparam int RecipShiftHp250 = 46;
   localparam int RecipShiftLp5k  = 47;
   localparam int RecipShiftLp550 = 45;
   localparam int RecipShiftHp1k2 = 46;

   localparam logic [63:0] DivHp250 = 64'd18384;
   localparam logic [63:0] DivLp5k  = 64'd34768;
   localparam logic [63:0] DivLp550 = 64'd16384;
   localparam logic [63:0] DivHp1k2 = 64'd16500;

   localparam logic [31:0] RecipHp250 =
      32'(((64'd1 << RecipShiftHp250) + DivHp250 - 64'd1) / DivHp250);
   localparam logic [31:0] RecipLp5k =
      32'(((64'd1 << RecipShiftLp5k) + DivLp5k - 64'd1) / DivLp5k);
   localparam logic [31:0] RecipLp550 =
      32'(((64'd1 << RecipShiftLp550) + DivLp550 - 64'd1) / DivLp550);
   localparam logic [31:0] RecipHp1k2 =
      32'(((64'd1 << RecipShiftHp1k2) + DivHp1k2 - 64'd1) / DivHp1k2);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEL,
      S_MUL,
      S_ACC,
      S_DLOAD,
      S_DIV,
      S_COMMIT,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic       start;
      logic       acc_clr;
      logic       mul;
      logic       div_load;
      logic       div_step;
      logic       commit;
      logic       out_load;
      logic [1:0] k;
      logic [2:0] tap;
   } sbq_cmd_type;

   function automatic logic signed [15:0] coef_get(input logic [1:0] k, input logic [2:0] tap);
      logic signed [15:0] c;
      c = '0;
      unique case (k)
         BQ_HP250: begin
            unique case (tap)
               TAP_B0:  c = 16'sd15620;
               TAP_B1:  c = -16'sd31241;
               TAP_A1:  c = 16'sd31179;
               TAP_B2:  c = 16'sd15620;
               TAP_A2:  c = -16'sd14920;
               default: c = '0;
            endcase
         end
         BQ_LP5K: begin
            unique case (tap)
               TAP_B0:  c = 16'sd9799;
               TAP_B1:  c = 16'sd19598;
               TAP_A1:  c = 16'sd21263;
               TAP_B2:  c = 16'sd9799;
               TAP_A2:  c = -16'sd8094;
               default: c = '0;
            endcase
         end
         BQ_LP550: begin
            unique case (tap)
               TAP_B0:  c = 16'sd389;
               TAP_B1:  c = -16'sd382;
               TAP_A1:  c = 16'sd30669;
               TAP_B2:  c = 16'sd389;
               TAP_A2:  c = -16'sd14512;
               default: c = '0;
            endcase
         end
         BQ_HP1K2: begin
            unique case (tap)
               TAP_B0:  c = 16'sd15284;
               TAP_B1:  c = -16'sd30569;
               TAP_A1:  c = 16'sd30440;
               TAP_B2:  c = 16'sd15284;
               TAP_A2:  c = -16'sd15284;
               default: c = '0;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic [31:0] recip_get(input logic [1:0] k);
      logic [31:0] m;
      unique case (k)
         BQ_HP250: m = RecipHp250;
         BQ_LP5K:  m = RecipLp5k;
         BQ_LP550: m = RecipLp550;
         BQ_HP1K2: m = RecipHp1k2;
      endcase
      return m;
   endfunction

   function automatic logic halve_get(input logic [1:0] k);
      return (k == BQ_LP5K) || (k == BQ_LP550);
   endfunction

endpackage

// ----- rtl/core/sbq_datapath.sv -----
// Datapath: history, shared multiplier, accumulator, reciprocal divider, output register.
module sbq_datapath
   import sbq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sbq_cmd_type        cmd,
   input  logic signed [15:0] req_sample_in,
   output logic signed [15:0] rsp_sample_out
);

   logic signed [15:0] cur_ff;
   logic signed [15:0] notch_a_ff;
   logic signed [15:0] x_ff [NumBiquads][2];
   logic signed [31:0] y_ff [NumBiquads][2];
   logic signed [31:0] prod_ff;
   logic               mul_vld_ff;
   logic signed [31:0] acc_ff;
   logic [31:0]        mag_ff;
   logic [63:0]        rprod_ff;
   logic               neg_ff;
   logic signed [15:0] out_ff;

   logic signed [31:0] operand;
   logic signed [15:0] coef;
   logic signed [47:0] prod_full;
   logic [31:0]        recip;
   logic [63:0]        rprod_full;
   logic [31:0]        quot;
   logic [31:0]        q_val;
   logic [31:0]        out_mag;
   logic [31:0]        out_val;
   logic signed [15:0] out16;

   always_comb begin
      operand = '0;
      unique case (cmd.tap)
         TAP_B0:  operand = {{16{cur_ff[15]}}, cur_ff};
         TAP_B1:  operand = {{16{x_ff[cmd.k][0][15]}}, x_ff[cmd.k][0]};
         TAP_A1:  operand = y_ff[cmd.k][0];
         TAP_B2:  operand = {{16{x_ff[cmd.k][1][15]}}, x_ff[cmd.k][1]};
         TAP_A2:  operand = y_ff[cmd.k][1];
         default: operand = '0;
      endcase
      coef      = coef_get(cmd.k, cmd.tap);
      prod_full = coef * operand;
   end

   // magnitude divide by reciprocal multiply, sign applied afterwards
   always_comb begin
      recip      = recip_get(cmd.k);
      rprod_full = mag_ff * recip;
      unique case (cmd.k)
         BQ_HP250: quot = 32'(rprod_ff >> RecipShiftHp250);
         BQ_LP5K:  quot = 32'(rprod_ff >> RecipShiftLp5k);
         BQ_LP550: quot = 32'(rprod_ff >> RecipShiftLp550);
         BQ_HP1K2: quot = 32'(rprod_ff >> RecipShiftHp1k2);
      endcase
      q_val   = neg_ff ? (32'd0 - quot) : quot;
      out_mag = halve_get(cmd.k) ? {1'b0, quot[31:1]} : quot;
      out_val = neg_ff ? (32'd0 - out_mag) : out_mag;
      out16   = out_val[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         for (int i = 0; i < NumBiquads; i++) begin
            x_ff[i][0] <= '0;
            x_ff[i][1] <= '0;
            y_ff[i][0] <= '0;
            y_ff[i][1] <= '0;
         end
      end else begin
         mul_vld_ff <= cmd.mul;
         if (cmd.commit) begin
            x_ff[cmd.k][1] <= x_ff[cmd.k][0];
            x_ff[cmd.k][0] <= cur_ff;
            y_ff[cmd.k][1] <= y_ff[cmd.k][0];
            y_ff[cmd.k][0] <= q_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[31:0];
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.div_load) begin
         neg_ff <= acc_ff[31];
         mag_ff <= acc_ff[31] ? (32'd0 - acc_ff) : acc_ff;
      end
      if (cmd.div_step) begin
         rprod_ff <= rprod_full;
      end
      if (cmd.start) begin
         cur_ff <= req_sample_in;
      end else if (cmd.commit) begin
         unique case (cmd.k)
            BQ_HP250, BQ_LP5K: cur_ff <= out16;
            BQ_LP550:          cur_ff <= cur_ff;
            BQ_HP1K2:          cur_ff <= notch_a_ff + out16;
         endcase
      end
      if (cmd.commit && (cmd.k == BQ_LP550)) begin
         notch_a_ff <= out16;
      end
      if (cmd.out_load) begin
         out_ff <= cur_ff;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

// ----- rtl/core/sbq_ctrl.sv -----
// Controller: sequences stages, taps and the divide; holds enables and result valid.
module sbq_ctrl
   import sbq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [0:0]  csr_wdata,
   output sbq_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [2:0] tap_ff, tap_in;
   logic       hp_en_ff, lp_en_ff, notch_en_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       stage_en;
   logic       slot_free;

   always_comb begin
      unique case (k_ff[1:0])
         BQ_HP250: stage_en = hp_en_ff;
         BQ_LP5K:  stage_en = lp_en_ff;
         BQ_LP550: stage_en = notch_en_ff;
         BQ_HP1K2: stage_en = notch_en_ff;
      endcase
      slot_free = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         S_IDLE: begin
            k_in = '0;
            if (req_valid) state_in = S_SEL;
         end
         S_SEL: begin
            tap_in = TAP_B0;
            priority if (k_ff == 3'(NumBiquads)) state_in = S_OUT;
            else if (stage_en) state_in = S_MUL;
            else k_in = k_ff + 3'd1;
         end
         S_MUL: begin
            if (tap_ff == TAP_A2) state_in = S_ACC;
            else tap_in = tap_ff + 3'd1;
         end
         S_ACC:   state_in = S_DLOAD;
         S_DLOAD: state_in = S_DIV;
         S_DIV:   state_in = S_COMMIT;
         S_COMMIT: begin
            k_in     = k_ff + 3'd1;
            state_in = S_SEL;
         end
         S_OUT: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.k        = k_ff[1:0];
      cmd.tap      = tap_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_SEL:    cmd.acc_clr  = 1'b1;
         S_MUL:    cmd.mul      = 1'b1;
         S_ACC:    cmd.mul      = 1'b0;
         S_DLOAD:  cmd.div_load = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_COMMIT: cmd.commit   = 1'b1;
         S_OUT:    cmd.out_load = slot_free;
         default:  cmd          = '0;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         tap_ff       <= '0;
         hp_en_ff     <= 1'b0;
         lp_en_ff     <= 1'b0;
         notch_en_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HIGHPASS_ENABLE: hp_en_ff    <= csr_wdata[0];
               CSR_LOWPASS_ENABLE:  lp_en_ff    <= csr_wdata[0];
               CSR_NOTCH_ENABLE:    notch_en_ff <= csr_wdata[0];
               default:             hp_en_ff    <= hp_en_ff;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (tap_ff <= TAP_A2))
      else $error("tap counter out of range");
   a_div_follows_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLOAD) |=> (state_ff == S_DIV))
      else $error("divide did not start after load");
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
   a_commit_enabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |-> stage_en && (k_ff < 3'(NumBiquads)))
      else $error("disabled stage committed");
`endif

endmodule

// ----- rtl/core/switchable_biquad_filter_chain.sv -----
// Top level of the switchable biquad filter chain: controller plus datapath.
//
//  Channel | Direction | Ports                         | Transfer when
//  req     | in        | req_valid/ready, req_sample_in | req_valid && req_ready
//  rsp     | out       | rsp_valid/ready, rsp_sample_out| rsp_valid && rsp_ready
//  csr     | in        | csr_we, csr_index, csr_wdata  | csr_we
//
// One item at a time. Up to 4 biquads are enabled (the notch counts as two). Every
// stage takes a select step; an enabled biquad adds its taps on the shared multiplier,
// draining the accumulator, loading the divider, the reciprocal multiply and writing
// history.
// Reset clears enables, all filter history and the result valid flag.
// A held result does not block the next req transfer; only the final
// write to the result register waits for the slot to free up.
module switchable_biquad_filter_chain
   import sbq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample_out,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [0:0]         csr_wdata
);

   sbq_cmd_type cmd;

   // sequencer: walks stages, taps and the divide
   sbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   // arithmetic and filter state
   sbq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
